// ===== sv/spc_pkg.sv =====
// spc_pkg: types and constants shared by the speed PI controller files.
// Depends on nothing; compile first.
`default_nettype none

package spc_pkg;

   localparam int SPEED_W  = 16;
   localparam int ERR_W    = 17;
   localparam int SUM_W    = 24;
   localparam int TERM_W   = 16;
   localparam int DRIVE_W  = 11;
   localparam int GAIN_W   = 15;
   localparam int WIN_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int P_SHIFT   = 14;
   localparam int I_SHIFT   = 11;
   localparam int SUM_SHIFT = 8;

   localparam logic signed [SUM_W-1:0]  SUM_LIMIT     = 24'sd1171070;
   localparam logic signed [SUM_W-1:0]  SUM_LIMIT_NEG = -24'sd1171070;
   localparam logic signed [TERM_W-1:0] DRIVE_MAX     = 16'sd800;
   localparam logic signed [TERM_W-1:0] DRIVE_MIN     = -16'sd800;

   localparam logic signed [SPEED_W-1:0] TARGET_RESET = 16'sd200;
   localparam logic [GAIN_W-1:0]         PGAIN_RESET  = 15'd300;
   localparam logic [GAIN_W-1:0]         IGAIN_RESET  = 15'd400;
   localparam logic [WIN_W-1:0]          WINDOW_RESET = 16'd1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_SPEED     = 2'd0,
      CSR_PROP_GAIN        = 2'd1,
      CSR_INTEGRAL_GAIN    = 2'd2,
      CSR_INTEGRATE_WINDOW = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] target_speed;
      logic [GAIN_W-1:0]         prop_gain;
      logic [GAIN_W-1:0]         integral_gain;
      logic [WIN_W-1:0]          integrate_window;
   } cfg_type;

   // per-stage load strobes of the datapath
   typedef struct packed {
      logic load_int;
      logic load_mul;
      logic load_out;
   } stage_ctl_type;

endpackage

`default_nettype wire

// ===== sv/spc_if.sv =====
// spc_if: valid/ready channel interfaces for speed samples and drive words.
// Depends on nothing.
`default_nettype none

interface spc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] measured_speed;

   modport source (output valid, output measured_speed, input ready);
   modport sink   (input valid, input measured_speed, output ready);
endinterface

interface spc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [10:0] drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

// ===== sv/spc_integrator.sv =====
// spc_integrator: error formation and conditional (anti-windup) integrator.
// Depends on spc_pkg.
`default_nettype none

module spc_integrator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            load,
   input  wire spc_pkg::cfg_type                cfg,
   input  wire logic signed [15:0]              speed,
   output logic signed [spc_pkg::ERR_W-1:0]     err_out,
   output logic signed [spc_pkg::TERM_W-1:0]    sum_hi_out
);
   import spc_pkg::*;

   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic signed [ERR_W-1:0]  err_ff, err;
   logic signed [TERM_W-1:0] sum_hi_ff;
   logic signed [ERR_W:0]    err_x, win_x;
   logic                     in_window, pos, neg, grow;

   assign err   = {cfg.target_speed[SPEED_W-1], cfg.target_speed} - {speed[SPEED_W-1], speed};
   assign err_x = {err[ERR_W-1], err};
   assign win_x = {2'b00, cfg.integrate_window};

   assign in_window = (err_x < win_x) && (err_x > -win_x);
   assign neg  = err[ERR_W-1];
   assign pos  = !neg && (err != '0);
   assign grow = (pos && (acc_ff < SUM_LIMIT)) || (neg && (acc_ff > SUM_LIMIT_NEG));

   always_comb begin
      if (!in_window) begin
         acc_in = '0;
      end else if (grow) begin
         acc_in = acc_ff + {{(SUM_W-ERR_W){err[ERR_W-1]}}, err};
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (load) begin
         acc_ff <= acc_in;
      end
   end

   // snapshot the updated sum for the multiply stage
   always_ff @(posedge clock) begin
      if (load) begin
         err_ff    <= err;
         sum_hi_ff <= acc_in[SUM_W-1:SUM_SHIFT];
      end
   end

   assign err_out    = err_ff;
   assign sum_hi_out = sum_hi_ff;

endmodule

`default_nettype wire

// ===== sv/spc_drive.sv =====
// spc_drive: proportional and integral products, wrap, sum and clamp.
// Depends on spc_pkg.
`default_nettype none

module spc_drive (
   input  wire logic                            clock,
   input  wire spc_pkg::stage_ctl_type          ctl,
   input  wire spc_pkg::cfg_type                cfg,
   input  wire logic signed [spc_pkg::ERR_W-1:0]  err,
   input  wire logic signed [spc_pkg::TERM_W-1:0] sum_hi,
   output logic signed [spc_pkg::DRIVE_W-1:0]   drive
);
   import spc_pkg::*;

   logic signed [ERR_W+GAIN_W:0]    p_prod;
   logic signed [TERM_W+GAIN_W:0]   i_prod;
   logic signed [TERM_W-1:0]        p_ff, i_ff, total, clamped;
   logic signed [DRIVE_W-1:0]       drive_ff;

   assign p_prod = err * $signed({1'b0, cfg.prop_gain});
   assign i_prod = sum_hi * $signed({1'b0, cfg.integral_gain});

   // keep only 16 bits above the shift: arithmetic shift, then wrap
   always_ff @(posedge clock) begin
      if (ctl.load_mul) begin
         p_ff <= p_prod[P_SHIFT+TERM_W-1:P_SHIFT];
         i_ff <= i_prod[I_SHIFT+TERM_W-1:I_SHIFT];
      end
   end

   assign total = p_ff + i_ff;

   always_comb begin
      if (total > DRIVE_MAX) begin
         clamped = DRIVE_MAX;
      end else if (total < DRIVE_MIN) begin
         clamped = DRIVE_MIN;
      end else begin
         clamped = total;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         drive_ff <= clamped[DRIVE_W-1:0];
      end
   end

   assign drive = drive_ff;

endmodule

`default_nettype wire

// ===== sv/speed_pi_controller.sv =====
// Speed PI controller with conditional integration and output clamp.
// An accepted sample moves through the stage registers to its drive word; a stalled rsp holds it.
// Throughput: one sample per cycle while rsp is not stalled; the accumulator add/compare is combinational.
// Four stages (capture, integrate, multiply, sum/clamp) each hold a word and
// close bubbles independently, so sampling continues while a result waits, until all are full.
// Reset (synchronous): clears stage valids and the accumulator, loads register defaults.
`default_nettype none

module speed_pi_controller (
   input  wire logic                              clock,
   input  wire logic                              reset,
   spc_req_if.sink                                req_bus,
   spc_rsp_if.source                              rsp_bus,
   input  wire logic                              csr_we,
   input  wire logic [spc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [spc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import spc_pkg::*;

   cfg_type                   cfg_ff;
   stage_ctl_type             ctl;
   logic                      cap_v_ff, int_v_ff, mul_v_ff, out_v_ff;
   logic                      en_cap, en_int, en_mul, en_out;
   logic signed [SPEED_W-1:0] speed_ff;
   logic signed [ERR_W-1:0]   err;
   logic signed [TERM_W-1:0]  sum_hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_speed     <= TARGET_RESET;
         cfg_ff.prop_gain        <= PGAIN_RESET;
         cfg_ff.integral_gain    <= IGAIN_RESET;
         cfg_ff.integrate_window <= WINDOW_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TARGET_SPEED:     cfg_ff.target_speed     <= $signed(csr_wdata);
            CSR_PROP_GAIN:        cfg_ff.prop_gain        <= csr_wdata[GAIN_W-1:0];
            CSR_INTEGRAL_GAIN:    cfg_ff.integral_gain    <= csr_wdata[GAIN_W-1:0];
            CSR_INTEGRATE_WINDOW: cfg_ff.integrate_window <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a stage may load when it is empty or its word moves on
   assign en_out = !out_v_ff || rsp_bus.ready;
   assign en_mul = !mul_v_ff || en_out;
   assign en_int = !int_v_ff || en_mul;
   assign en_cap = !cap_v_ff || en_int;

   assign req_bus.ready = en_cap;

   assign ctl.load_int = en_int && cap_v_ff;
   assign ctl.load_mul = en_mul && int_v_ff;
   assign ctl.load_out = en_out && mul_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_v_ff <= 1'b0;
         int_v_ff <= 1'b0;
         mul_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (en_cap) cap_v_ff <= req_bus.valid;
         if (en_int) int_v_ff <= cap_v_ff;
         if (en_mul) mul_v_ff <= int_v_ff;
         if (en_out) out_v_ff <= mul_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_cap && req_bus.valid) begin
         speed_ff <= req_bus.measured_speed;
      end
   end

   spc_integrator u_integrator (
      .clock      (clock),
      .reset      (reset),
      .load       (ctl.load_int),
      .cfg        (cfg_ff),
      .speed      (speed_ff),
      .err_out    (err),
      .sum_hi_out (sum_hi)
   );

   spc_drive u_drive (
      .clock  (clock),
      .ctl    (ctl),
      .cfg    (cfg_ff),
      .err    (err),
      .sum_hi (sum_hi),
      .drive  (rsp_bus.drive)
   );

   assign rsp_bus.valid = out_v_ff;

endmodule

`default_nettype wire

// ===== sv/spc_checker.sv =====
// spc_checker: port-level checks of the speed PI controller, bound to the top level.
// Depends on speed_pi_controller and its channel interfaces.
`default_nettype none

module spc_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [10:0] rsp_drive
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("drive word valid right after reset");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
      else $error("stalled drive word dropped or changed");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive <= 11'sd800) && (rsp_drive >= -11'sd800))
      else $error("drive word outside clamp range");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      ($past(req_valid && req_ready, 4) && $past(rsp_ready, 1) && $past(rsp_ready, 2)
       && $past(rsp_ready, 3) && !$past(reset, 1) && !$past(reset, 2)
       && !$past(reset, 3) && !$past(reset, 4)) |-> rsp_valid)
      else $error("accepted sample did not reach output in four cycles");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      rsp_ready && !$past(reset) |-> req_ready)
      else $error("input stalled while output drains");

endmodule

bind speed_pi_controller spc_checker u_spc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_drive (rsp_bus.drive)
);

`default_nettype wire

// ===== tb/sv/speed_pi_controller_test.sv =====
// speed_pi_controller_test: self-checking bench for the speed PI controller, driving speed
// samples and register loads, comparing each drive word with an in-bench predictor or a typed-in value.
// Depends on spc_pkg, spc_if and speed_pi_controller.
`timescale 1ns / 1ps

module speed_pi_controller_test;
   import spc_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_ITEMS  = 106;
   localparam int NUM_PHASES   = 8;
   localparam int PRINT_CAP    = 40;

   typedef enum logic [1:0] {ROW_LOAD, ROW_CHECK, ROW_FIXED} row_kind_type;

   typedef struct packed {
      row_kind_type                kind;
      logic [CSR_DATA_W-1:0]       target;
      logic [CSR_DATA_W-1:0]       pgain;
      logic [CSR_DATA_W-1:0]       igain;
      logic [CSR_DATA_W-1:0]       window;
      logic signed [SPEED_W-1:0]   speed;
      logic signed [DRIVE_W-1:0]   drive;
   } directed_row_type;

   // drive is typed in only on ROW_FIXED rows
   localparam directed_row_type DIRECTED [25] = '{
      '{ROW_FIXED, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd200,   11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h8000,   11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd32767, 11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd0,     11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd199,   11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd201,   11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, -16'sd799,  11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd1199,  11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd1200,  11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, -16'sd800,  11'sd0},
      '{ROW_LOAD,  16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'sd0, 11'sd0},
      '{ROW_FIXED, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd32767, 11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h8000,   11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd32766, 11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, -16'sd32767, 11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, -16'sd32767, 11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, -16'sd32767, 11'sd0},
      '{ROW_LOAD,  16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'sd0, 11'sd0},
      '{ROW_FIXED, 16'h0, 16'h0, 16'h0, 16'h0, 16'h8000,   11'sd0},
      '{ROW_FIXED, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd32767, 11'sd0},
      '{ROW_FIXED, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd0,     11'sd0},
      '{ROW_LOAD,  16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'sd0, 11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd32766, 11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd32766, 11'sd0},
      '{ROW_CHECK, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd32766, 11'sd0}
   };

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   spc_req_if speed_bus ();
   spc_rsp_if drive_bus ();

   speed_pi_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (speed_bus),
      .rsp_bus   (drive_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the registers and the integrator
   cfg_type                   mirror;
   logic signed [SUM_W-1:0]   error_sum_m;

   logic signed [DRIVE_W-1:0] drive_expect [$];
   bit                        sample_pinned;
   logic signed [DRIVE_W-1:0] sample_pin_drive;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   bit          hold_req = 1'b0;

   int mismatch_count = 0;
   int samples_taken = 0;
   int words_checked = 0;
   int config_loads = 0;
   int quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [DRIVE_W-1:0] next_drive(
      input logic signed [SPEED_W-1:0] speed);
      logic signed [ERR_W-1:0]  err;
      logic signed [TERM_W-1:0] p_term, i_term, total;
      longint                   e, w, wide;
      err = $signed(mirror.target_speed) - speed;
      e = longint'(err);
      w = longint'(mirror.integrate_window);
      if (e > -w && e < w) begin
         if ((e > 0 && error_sum_m < SUM_LIMIT) || (e < 0 && error_sum_m > SUM_LIMIT_NEG))
            error_sum_m = error_sum_m + err;
      end else begin
         error_sum_m = '0;
      end
      wide = (e * longint'(mirror.prop_gain)) >>> P_SHIFT;
      p_term = wide[TERM_W-1:0];
      wide = ((longint'(error_sum_m) >>> SUM_SHIFT) * longint'(mirror.integral_gain)) >>> I_SHIFT;
      i_term = wide[TERM_W-1:0];
      total = p_term + i_term;
      if (total > DRIVE_MAX)
         total = DRIVE_MAX;
      else if (total < DRIVE_MIN)
         total = DRIVE_MIN;
      return total[DRIVE_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      // keep the log short on a badly broken build
      if (mismatch_count <= PRINT_CAP)
         $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   // called at a falling edge; returns at a falling edge
   task automatic put_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic load_config(input logic [CSR_DATA_W-1:0] target, pgain, igain, window);
      put_csr(CSR_TARGET_SPEED, target);
      put_csr(CSR_PROP_GAIN, pgain);
      put_csr(CSR_INTEGRAL_GAIN, igain);
      put_csr(CSR_INTEGRATE_WINDOW, window);
      csr_we <= 1'b0;
      mirror.target_speed = target;
      mirror.prop_gain = pgain[GAIN_W-1:0];
      mirror.integral_gain = igain[GAIN_W-1:0];
      mirror.integrate_window = window;
      config_loads++;
   endtask

   // drop valid and wait for every drive word still owed
   task automatic quiesce();
      speed_bus.valid <= 1'b0;
      while (drive_expect.size() != 0)
         @(negedge clock);
   endtask

   task automatic send_speed(input logic signed [SPEED_W-1:0] speed, input bit pinned,
                             input logic signed [DRIVE_W-1:0] drive);
      int unsigned gap;
      gap = 0;
      while (gap < 200 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap != 0) begin
         speed_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      speed_bus.valid <= 1'b1;
      speed_bus.measured_speed <= speed;
      sample_pinned <= pinned;
      sample_pin_drive <= drive;
      do @(posedge clock); while (!speed_bus.ready);
      @(negedge clock);
   endtask

   // receiver: random stalls plus one long hold-off on request
   initial begin : receiver
      drive_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            drive_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end
         drive_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : scoreboard
      logic signed [DRIVE_W-1:0] predicted, wanted;
      if (!reset) begin
         if (speed_bus.valid && speed_bus.ready) begin
            predicted = next_drive(speed_bus.measured_speed);
            drive_expect.push_back(sample_pinned ? sample_pin_drive : predicted);
            samples_taken++;
         end
         if (drive_bus.valid && drive_bus.ready) begin
            if (drive_expect.size() == 0) begin
               report_mismatch($sformatf("drive word %0d with no sample owed", drive_bus.drive));
            end else begin
               wanted = drive_expect.pop_front();
               if (drive_bus.drive !== wanted)
                  report_mismatch($sformatf("drive %0d, expected %0d (word %0d)",
                                            drive_bus.drive, wanted, words_checked));
               words_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (speed_bus.valid && speed_bus.ready)
          || (drive_bus.valid && drive_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("** speed_pi_controller: FAILED **");
            $finish;
         end
      end
   end

   initial begin : stimulus
      directed_row_type          row;
      logic signed [SPEED_W-1:0] speed;
      longint                    e, s;
      int unsigned               w, mag, r;
      int                        run_left;
      bit                        run_down;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_TARGET_SPEED;
      csr_wdata = '0;
      speed_bus.valid = 1'b0;
      speed_bus.measured_speed = '0;
      sample_pinned = 1'b0;
      sample_pin_drive = '0;
      mirror = '{TARGET_RESET, PGAIN_RESET, IGAIN_RESET, WINDOW_RESET};
      error_sum_m = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 15;
      rsp_stall_pct = 15;
      foreach (DIRECTED[k]) begin
         row = DIRECTED[k];
         case (row.kind)
            ROW_LOAD: begin
               quiesce();
               load_config(row.target, row.pgain, row.igain, row.window);
            end
            ROW_FIXED: send_speed(row.speed, 1'b1, row.drive);
            default:   send_speed(row.speed, 1'b0, '0);
         endcase
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         quiesce();
         case (phase)
            0: load_config(16'h0000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
            1: load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            2: load_config(16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF);
            3: load_config(16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001);
            4: load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'h0000);
            default: load_config(16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom_range(65535, 1)));
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 84; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 84; end
            default: begin send_idle_pct = 15; rsp_stall_pct = 15; end
         endcase
         w = 32'(mirror.integrate_window);
         run_left = 0;
         run_down = 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < 15) begin
               speed = 16'($urandom);
            end else begin
               // runs of same-sign errors push the integrator into its limits
               if (run_left == 0) begin
                  run_left = $urandom_range(60, 5);
                  run_down = 1'($urandom_range(1));
               end
               run_left--;
               if (w == 0 || r < 22)
                  mag = w;
               else if (r < 30)
                  mag = w - 1;
               else
                  mag = $urandom_range(w - 1);
               e = run_down ? -longint'(mag) : longint'(mag);
               s = longint'($signed(mirror.target_speed)) - e;
               if (s < -32768 || s > 32767)
                  speed = 16'($urandom);
               else
                  speed = s[SPEED_W-1:0];
            end
            if (phase == 0 && n == 20)
               hold_req = 1'b1;
            send_speed(speed, 1'b0, '0);
         end
      end

      quiesce();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (drive_expect.size() != 0)
         report_mismatch($sformatf("%0d drive words never arrived", drive_expect.size()));

      $display("Ran %0d speed samples over %0d register loads; %0d drive words compared.",
               samples_taken, config_loads, words_checked);
      $display("Covered window edges, integrator limits, term wrap, clamp, idle and stall mixes.");
      if (mismatch_count == 0)
         $display("** speed_pi_controller: PASSED **");
      else
         $display("** speed_pi_controller: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/spc_pkg.sv
sv/spc_if.sv
sv/spc_integrator.sv
sv/spc_drive.sv
sv/speed_pi_controller.sv
sv/spc_checker.sv
tb/sv/speed_pi_controller_test.sv
